// File: design/ewso_pkg.sv
// ----------------------------------------------------------------------------
// Encoder windowed speed observer package
// Shared types, codes and constants of the speed observer.
// ----------------------------------------------------------------------------
package ewso_pkg;

  typedef struct packed {
    logic               clear;
    logic               sample_ok;
    logic [15:0]        sample_number;
    logic [15:0]        angle_count;
    logic signed [31:0] applied_speed_ref;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] speed_mech;
    logic signed [31:0] speed_elec;
    logic [31:0]        rotor_position;
    logic               speed_settled;
  } out_beat_t;

  typedef enum logic [2:0] {
    ST_SKIPPED     = 3'd0,
    ST_PRIMED      = 3'd1,
    ST_ACCUMULATED = 3'd2,
    ST_NEW_SPEED   = 3'd3,
    ST_CLEARED     = 3'd4
  } status_code_t;

  localparam logic [2:0] CFG_REVERSE   = 3'd0;
  localparam logic [2:0] CFG_POLE      = 3'd1;
  localparam logic [2:0] CFG_ALPHA     = 3'd2;
  localparam logic [2:0] CFG_SCALE     = 3'd3;
  localparam logic [2:0] CFG_ZH_SCALE  = 3'd4;
  localparam logic [2:0] CFG_ZH_MIN    = 3'd5;

  localparam int DIV_BITS = 64;

  typedef enum logic [3:0] {
    S_IDLE, S_EVAL, S_MULQ, S_DIVQ, S_RAW, S_MULT, S_DIVT,
    S_FMUL, S_FADD, S_GUARD, S_EMIT
  } fsm_state_t;

  typedef struct packed {
    logic load;
    logic eval;
    logic mulq;
    logic div;
    logic raw;
    logic mult;
    logic fmul;
    logic fadd;
    logic guard;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic window;
    logic div_done;
    logic out_free;
  } dp_stat_t;

endpackage

// File: design/ewso_ctrl.sv
// ----------------------------------------------------------------------------
// Speed observer controller
// Sequences evaluation, the two divisions, the filter and the result beat.
// ----------------------------------------------------------------------------
module ewso_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output ewso_pkg::dp_cmd_t cmd,
  input  ewso_pkg::dp_stat_t stat
);
  import ewso_pkg::*;

  fsm_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_stall = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        state_next = stat.window ? S_MULQ : S_EMIT;
      end
      S_MULQ: begin
        cmd.mulq = 1'b1;
        state_next = S_DIVQ;
      end
      S_DIVQ: begin
        cmd.div = 1'b1;
        if (stat.div_done) state_next = S_RAW;
      end
      S_RAW: begin
        cmd.raw = 1'b1;
        state_next = S_MULT;
      end
      S_MULT: begin
        cmd.mult = 1'b1;
        state_next = S_DIVT;
      end
      S_DIVT: begin
        cmd.div = 1'b1;
        if (stat.div_done) state_next = S_FMUL;
      end
      S_FMUL: begin
        cmd.fmul = 1'b1;
        state_next = S_FADD;
      end
      S_FADD: begin
        cmd.fadd = 1'b1;
        state_next = S_GUARD;
      end
      S_GUARD: begin
        cmd.guard = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// File: design/ewso_dp.sv
// ----------------------------------------------------------------------------
// Speed observer datapath
// Observer state, configuration registers, shared divider and output register.
// ----------------------------------------------------------------------------
module ewso_dp #(
  parameter int WINDOW_SAMPLES = 20,
  parameter int ANGLE_BITS     = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  ewso_pkg::in_beat_t  in_data,
  input  ewso_pkg::dp_cmd_t   cmd,
  output ewso_pkg::dp_stat_t  stat,
  output logic                out_valid,
  input  logic                out_stall,
  output ewso_pkg::out_beat_t out_data
);
  import ewso_pkg::*;

  localparam logic [15:0] WIN = 16'(WINDOW_SAMPLES);

  // Configuration.
  logic        reverse_direction;
  logic [6:0]  pole_pairs;
  logic [16:0] lpf_alpha;
  logic [31:0] speed_scale;
  logic [15:0] zero_hold_scale;
  logic [30:0] zero_hold_min;

  always_ff @(posedge clk) begin
    if (rst) begin
      reverse_direction <= 1'b0;
      pole_pairs        <= 7'd7;
      lpf_alpha         <= 17'd65536;
      speed_scale       <= 32'd62829824;
      zero_hold_scale   <= 16'd256;
      zero_hold_min     <= 31'd0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_REVERSE:  reverse_direction <= cfg_data[0];
        CFG_POLE:     pole_pairs        <= cfg_data[6:0];
        CFG_ALPHA:    lpf_alpha         <= cfg_data[16:0];
        CFG_SCALE:    speed_scale       <= cfg_data;
        CFG_ZH_SCALE: zero_hold_scale   <= cfg_data[15:0];
        CFG_ZH_MIN:   zero_hold_min     <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // Observer state.
  in_beat_t              item;
  logic [15:0]           last_sample_number;
  logic [ANGLE_BITS-1:0] previous_angle;
  logic [31:0]           continuous_position;
  logic [31:0]           window_start_position;
  logic [15:0]           window_count;
  logic                  primed;
  logic                  ready;
  logic signed [31:0]    filter_value;
  logic signed [31:0]    held_speed;
  logic [2:0]            status;

  // Window work registers.
  logic [15:0]           count;
  logic [31:0]           pos_mag;
  logic                  pos_neg;
  logic [DIV_BITS-1:0]   dvd;
  logic [15:0]           rem;
  logic [5:0]            div_cnt;
  logic signed [31:0]    raw;
  logic signed [31:0]    fv0;
  logic signed [50:0]    prod;
  logic signed [31:0]    fv_new;

  // Evaluation of a fresh sample.
  logic [ANGLE_BITS-1:0] ang_in, ang, d;
  logic [31:0]           sd, new_pos, u;
  logic [16:0]           wc_sum;
  logic [15:0]           wc_sat;
  logic                  fresh, is_window;

  always_comb begin
    ang_in   = ANGLE_BITS'(item.angle_count);
    ang      = reverse_direction ? (ANGLE_BITS'(0) - ang_in) : ang_in;
    d        = ang - previous_angle;
    sd       = 32'(signed'(d));
    new_pos  = continuous_position + sd;
    wc_sum   = {1'b0, window_count} + {1'b0, item.sample_number - last_sample_number};
    wc_sat   = wc_sum[16] ? 16'hFFFF : wc_sum[15:0];
    u        = new_pos - window_start_position;
    fresh    = !item.clear && item.sample_ok && (item.sample_number != last_sample_number);
    is_window = fresh && primed && (wc_sat >= WIN);
  end

  // Divider step.
  logic [16:0] rem_sh;
  logic        q_bit;
  always_comb begin
    rem_sh = {rem, dvd[DIV_BITS-1]};
    q_bit  = (rem_sh >= {1'b0, count});
  end

  // Raw speed from the quotient.
  logic signed [31:0] raw_next;
  always_comb begin
    if (pos_neg) begin
      raw_next = (dvd > 64'h8000_0000) ? 32'sh8000_0000 : -signed'(dvd[31:0]);
    end else begin
      raw_next = (dvd > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : signed'(dvd[31:0]);
    end
  end

  // Filter.
  logic [16:0]        alpha_eff;
  logic signed [31:0] fv_base;
  logic signed [32:0] diff;
  logic [50:0]        prod_mag;
  logic [34:0]        step_mag;
  logic signed [36:0] fv_sum;
  always_comb begin
    alpha_eff = (lpf_alpha > 17'd65536) ? 17'd65536 : lpf_alpha;
    fv_base   = ready ? filter_value : raw;
    diff      = {raw[31], raw} - {fv_base[31], fv_base};
    prod_mag  = prod[50] ? 51'(-prod) : 51'(prod);
    step_mag  = 35'((prod_mag + 51'd32768) >> 16);
    fv_sum    = {{5{fv0[31]}}, fv0} +
                (prod[50] ? -signed'({2'b00, step_mag}) : signed'({2'b00, step_mag}));
  end

  // Zero-hold guard; the threshold is the second quotient.
  logic [DIV_BITS-1:0] thr;
  logic [32:0]         ref_mag, spd_mag;
  logic signed [31:0]  guarded;
  always_comb begin
    thr     = (dvd < {33'd0, zero_hold_min}) ? {33'd0, zero_hold_min} : dvd;
    ref_mag = item.applied_speed_ref[31] ? 33'(-{1'b1, item.applied_speed_ref})
                                         : {1'b0, item.applied_speed_ref};
    spd_mag = filter_value[31] ? 33'(-{1'b1, filter_value}) : {1'b0, filter_value};
    guarded = filter_value;
    if (dvd != '0 && {31'd0, ref_mag} <= thr && {31'd0, spd_mag} <= thr) guarded = '0;
  end

  // Electrical speed.
  logic signed [39:0] elec_full;
  logic signed [31:0] elec;
  always_comb begin
    elec_full = held_speed * signed'({1'b0, pole_pairs});
    if (elec_full > 40'sh00_7FFF_FFFF) elec = 32'sh7FFF_FFFF;
    else if (elec_full < -40'sh00_8000_0000) elec = 32'sh8000_0000;
    else elec = elec_full[31:0];
  end

  assign fv_new = (fv_sum > 37'sh0_7FFF_FFFF) ? 32'sh7FFF_FFFF :
                  (fv_sum < -37'sh0_8000_0000) ? 32'sh8000_0000 : fv_sum[31:0];

  always_ff @(posedge clk) begin
    if (cmd.load) item <= in_data;
    if (cmd.eval && is_window) begin
      count   <= wc_sat;
      pos_neg <= u[31];
      pos_mag <= u[31] ? (32'd0 - u) : u;
    end
    if (cmd.mulq) dvd <= 64'(pos_mag) * 64'(speed_scale);
    if (cmd.mult) dvd <= {24'd0, 40'((48'(speed_scale) * 48'(zero_hold_scale)) >> 8)};
    if (cmd.mulq || cmd.mult) rem <= '0;
    if (cmd.div) begin
      dvd <= {dvd[DIV_BITS-2:0], q_bit};
      rem <= q_bit ? 16'(rem_sh - {1'b0, count}) : rem_sh[15:0];
    end
    if (cmd.raw) raw <= raw_next;
    if (cmd.fmul) begin
      fv0  <= fv_base;
      prod <= diff * signed'({1'b0, alpha_eff});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.mulq || cmd.mult) begin
      div_cnt <= '0;
    end else if (cmd.div) begin
      div_cnt <= div_cnt + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_sample_number    <= '0;
      previous_angle        <= '0;
      continuous_position   <= '0;
      window_start_position <= '0;
      window_count          <= '0;
      primed                <= 1'b0;
      ready                 <= 1'b0;
      filter_value          <= '0;
      held_speed            <= '0;
      status                <= ST_SKIPPED;
    end else begin
      if (cmd.eval) begin
        if (item.clear) begin
          last_sample_number    <= '0;
          previous_angle        <= '0;
          continuous_position   <= '0;
          window_start_position <= '0;
          window_count          <= '0;
          primed                <= 1'b0;
          ready                 <= 1'b0;
          filter_value          <= '0;
          held_speed            <= '0;
          status                <= ST_CLEARED;
        end else if (!fresh) begin
          status <= ST_SKIPPED;
        end else if (!primed) begin
          last_sample_number    <= item.sample_number;
          previous_angle        <= ang;
          continuous_position   <= 32'(ang);
          window_start_position <= 32'(ang);
          window_count          <= '0;
          primed                <= 1'b1;
          ready                 <= 1'b0;
          held_speed            <= '0;
          status                <= ST_PRIMED;
        end else begin
          last_sample_number  <= item.sample_number;
          previous_angle      <= ang;
          continuous_position <= new_pos;
          if (is_window) begin
            window_start_position <= new_pos;
            window_count          <= '0;
            status                <= ST_NEW_SPEED;
          end else begin
            window_count <= wc_sat;
            status       <= ST_ACCUMULATED;
          end
        end
      end
      if (cmd.fadd) begin
        filter_value <= fv_new;
        ready        <= 1'b1;
      end
      if (cmd.guard) held_speed <= guarded;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data.status         <= status;
      out_data.speed_mech     <= held_speed;
      out_data.speed_elec     <= elec;
      out_data.rotor_position <= continuous_position;
      out_data.speed_settled  <= ready;
    end
  end

  assign stat.window   = is_window;
  assign stat.div_done = (div_cnt == 6'(DIV_BITS - 1));
  assign stat.out_free = !out_valid || !out_stall;

  a_win_bound: assert property (@(posedge clk) disable iff (rst)
    window_count < WIN) else $error("window count reached the window length");
  a_new_ready: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == ST_NEW_SPEED |-> out_data.speed_settled)
    else $error("new speed reported before ready");
  a_clear_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == ST_CLEARED |->
    out_data.speed_mech == 0 && out_data.rotor_position == 0 && !out_data.speed_settled)
    else $error("cleared beat carries stale state");

endmodule

// File: design/encoder_windowed_speed_observer.sv
// ----------------------------------------------------------------------------
// Encoder windowed speed observer
// M-method speed estimate from encoder samples with low-pass filter and
// zero-hold guard.
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  in        in_valid / in_stall  in_data   (ewso_pkg::in_beat_t)
//  out       out_valid/out_stall  out_data  (ewso_pkg::out_beat_t)
//  cfg       cfg_write            cfg_index, cfg_data
//
// An input beat that ends without a speed update goes through accept,
// evaluate and the output register load. A beat that closes a window goes
// through accept, evaluate, a product load, 64 steps of the shared restoring
// divider for the raw speed, the raw speed, a second product load, 64 more
// divider steps for the zero-hold threshold, two filter steps, the guard and
// the output load. The divider retires one quotient bit per cycle.
// Reset is synchronous and returns configuration and observer state to their
// defaults. The next beat is accepted while a finished result still waits
// behind out_stall; only the following result waits for the output register.
module encoder_windowed_speed_observer #(
  parameter int WINDOW_SAMPLES = 20,
  parameter int ANGLE_BITS     = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  ewso_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ewso_pkg::out_beat_t out_data
);
  import ewso_pkg::*;

  // Commands from the sequencer and status back from the datapath.
  dp_cmd_t  cmd;
  dp_stat_t stat;

  ewso_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .stat     (stat)
  );

  // The datapath holds the observer state, the configuration and the divider.
  ewso_dp #(
    .WINDOW_SAMPLES (WINDOW_SAMPLES),
    .ANGLE_BITS     (ANGLE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// Speed observer testbench
// Drives encoder sample beats with random gaps and output stalls, predicts
// every result beat in a scoreboard and compares them field by field. The run
// walks through several register settings, the extremes among them.
// ----------------------------------------------------------------------------
module testbench;
  import ewso_pkg::*;

  // Holds the observer state mirror and the queue of predicted result beats.
  class speed_scoreboard;
    bit        rev;
    bit [6:0]  poles;
    bit [16:0] alpha_reg;
    bit [31:0] scale;
    bit [15:0] zh_scale;
    bit [30:0] zh_min;

    bit [15:0] last_sn, prev_ang;
    bit [31:0] pos, win_start;
    int unsigned win_cnt;
    bit        primed, ready;
    longint    filt, held;

    out_beat_t predicted_beats[$];
    int        errors;
    int        n_speed, n_checked;

    function void reset_all();
      clear_obs();
      rev = 0; poles = 7; alpha_reg = 65536; scale = 62829824;
      zh_scale = 256; zh_min = 0;
    endfunction

    function void clear_obs();
      last_sn = 0; prev_ang = 0; pos = 0; win_start = 0; win_cnt = 0;
      primed = 0; ready = 0; filt = 0; held = 0;
    endfunction

    function void write_reg(bit [2:0] idx, bit [31:0] val);
      case (idx)
        CFG_REVERSE:  rev = val[0];
        CFG_POLE:     poles = val[6:0];
        CFG_ALPHA:    alpha_reg = val[16:0];
        CFG_SCALE:    scale = val;
        CFG_ZH_SCALE: zh_scale = val[15:0];
        CFG_ZH_MIN:   zh_min = val[30:0];
        default: ;
      endcase
    endfunction

    function longint sat(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint mag(longint v);
      return v < 0 ? -v : v;
    endfunction

    function void push_held(bit [2:0] st);
      out_beat_t b;
      b.status = st;
      b.speed_mech = held[31:0];
      b.speed_elec = 32'(sat(held * longint'(poles)));
      b.rotor_position = pos;
      b.speed_settled = ready;
      predicted_beats.push_back(b);
    endfunction

    // Note one accepted input beat and queue the result it should cause.
    function void note_sample(in_beat_t s);
      bit [15:0] ang, d;
      bit [31:0] u, cnt;
      longint sd, raw, diff, prod, m, spd, a;
      bit [63:0] q, thr;
      out_beat_t b;
      if (s.clear) begin
        clear_obs();
        b = '0;
        b.status = ST_CLEARED;
        predicted_beats.push_back(b);
        return;
      end
      if (!s.sample_ok || s.sample_number == last_sn) begin
        push_held(ST_SKIPPED);
        return;
      end
      ang = rev ? 16'(-s.angle_count) : s.angle_count;
      cnt = 32'(16'(s.sample_number - last_sn));
      last_sn = s.sample_number;
      if (!primed) begin
        prev_ang = ang; pos = {16'd0, ang}; win_start = pos; win_cnt = 0;
        primed = 1; ready = 0; held = 0;
        push_held(ST_PRIMED);
        return;
      end
      d = ang - prev_ang;
      sd = longint'($signed(d));
      prev_ang = ang;
      pos = pos + 32'(sd);
      win_cnt = win_cnt + cnt;
      if (win_cnt > 65535) win_cnt = 65535;
      if (win_cnt < 20) begin
        push_held(ST_ACCUMULATED);
        return;
      end
      cnt = win_cnt;
      u = pos - win_start;
      q = u[31] ? (64'd1 << 32) - u : 64'(u);
      q = q * scale / cnt;
      if (u[31]) raw = q > (64'd1 << 31) ? -64'sd2147483648 : -longint'(q);
      else raw = q > 64'd2147483647 ? 64'sd2147483647 : longint'(q);
      win_start = pos;
      win_cnt = 0;
      if (!ready) begin
        filt = raw; ready = 1;
      end
      a = alpha_reg > 65536 ? 65536 : alpha_reg;
      diff = raw - filt;
      prod = diff * a;
      m = (mag(prod) + 32768) >>> 16;
      filt = sat(filt + (prod < 0 ? -m : m));
      spd = filt;
      thr = 64'(scale) * zh_scale / (64'(cnt) * 256);
      if (thr != 0) begin
        if (thr < zh_min) thr = 64'(zh_min);
        if (mag(longint'(s.applied_speed_ref)) <= thr && mag(spd) <= thr) spd = 0;
      end
      held = spd;
      n_speed++;
      push_held(ST_NEW_SPEED);
    endfunction

    // Compare one result beat with the oldest prediction.
    function void check_result(out_beat_t got);
      out_beat_t e;
      if (predicted_beats.size() == 0) begin
        $display("%0t: unexpected result beat %p", $time, got);
        errors++;
        return;
      end
      e = predicted_beats.pop_front();
      n_checked++;
      if (got.status !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, got.status);
        errors++;
      end
      if (got.speed_mech !== e.speed_mech) begin
        $display("%0t: speed_mech expected %0d actual %0d", $time, e.speed_mech,
                 got.speed_mech);
        errors++;
      end
      if (got.speed_elec !== e.speed_elec) begin
        $display("%0t: speed_elec expected %0d actual %0d", $time, e.speed_elec,
                 got.speed_elec);
        errors++;
      end
      if (got.rotor_position !== e.rotor_position) begin
        $display("%0t: rotor_position expected %0h actual %0h", $time,
                 e.rotor_position, got.rotor_position);
        errors++;
      end
      if (got.speed_settled !== e.speed_settled) begin
        $display("%0t: speed_settled expected %0b actual %0b", $time, e.speed_settled,
                 got.speed_settled);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  in_beat_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_beat_t   out_data;

  speed_scoreboard sb;

  // Stimulus state kept between beats so that well-formed sample streams
  // keep a running counter and a smoothly moving angle.
  bit [15:0] stream_sn;
  bit [15:0] stream_ang;
  int        stream_vel;
  bit        stall_enable;

  encoder_windowed_speed_observer dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Generous fixed limit: it covers the window-closing beats with their two
  // divisions, plus long gaps and stalls.
  initial begin
    #20000000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Both accepted channels are sampled at the clock edge; the scoreboard
  // sees inputs as they are accepted and outputs as they leave.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_sample(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
    end
  end

  // Random receiver stalls: mostly short runs, a few long, and quiet
  // stretches where the output is never stalled.
  always @(posedge clk) begin
    if (rst || !stall_enable) out_stall <= 1'b0;
    else if ($urandom_range(99) < 25) out_stall <= ($urandom_range(9) == 0) ?
                                                   1'b1 : ~out_stall;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(3);
    return $urandom_range(60, 10);
  endfunction

  // Present one beat and hold it until the block accepts it. With no gap
  // the valid stays high and the next beat follows directly.
  task automatic send_beat(in_beat_t b);
    int g;
    g = gap_len();
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.predicted_beats.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_cfg(bit [2:0] idx, bit [31:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  function automatic in_beat_t sample_beat(bit clr, bit ok, bit [15:0] sn,
                                           bit [15:0] ang, bit [31:0] ref_spd);
    in_beat_t b;
    b.clear = clr;
    b.sample_ok = ok;
    b.sample_number = sn;
    b.angle_count = ang;
    b.applied_speed_ref = ref_spd;
    return b;
  endfunction

  // Next beat of a well-formed stream, with occasional noise: skipped,
  // stale or clearing beats, counter jumps and angle jumps.
  function automatic in_beat_t stream_beat();
    int r;
    bit [31:0] ref_spd;
    r = $urandom_range(99);
    ref_spd = ($urandom_range(3) == 0) ? $urandom : 32'($signed($urandom_range(4000)) -
                                                        2000);
    if (r < 2) return sample_beat(1'b1, 1'($urandom), 16'($urandom), 16'($urandom),
                                  $urandom);
    if (r < 6) return sample_beat(1'b0, 1'b0, 16'($urandom), 16'($urandom), ref_spd);
    if (r < 9) return sample_beat(1'b0, 1'b1, stream_sn, 16'($urandom), ref_spd);
    if (r < 12) stream_sn = stream_sn + 16'($urandom_range(30, 2));
    else if (r < 13) stream_sn = 16'($urandom);
    else stream_sn = stream_sn + 16'd1;
    if (r >= 97) stream_ang = 16'($urandom);
    else stream_ang = stream_ang + 16'(stream_vel + $signed($urandom_range(6)) - 3);
    return sample_beat(1'b0, 1'b1, stream_sn, stream_ang, ref_spd);
  endfunction

  task automatic random_phase(int n);
    int i;
    stream_vel = ($urandom_range(4) == 0) ? $signed($urandom_range(65535)) - 32768 :
                 $signed($urandom_range(400)) - 200;
    for (i = 0; i < n; i++) send_beat(stream_beat());
  endtask

  task automatic set_regs(bit rv, bit [6:0] pp, bit [16:0] al, bit [31:0] sc,
                          bit [15:0] zs, bit [30:0] zm);
    wait_drained();
    write_cfg(CFG_REVERSE, 32'(rv));
    write_cfg(CFG_POLE, 32'(pp));
    write_cfg(CFG_ALPHA, 32'(al));
    write_cfg(CFG_SCALE, sc);
    write_cfg(CFG_ZH_SCALE, 32'(zs));
    write_cfg(CFG_ZH_MIN, 32'(zm));
    cfg_write <= 1'b0;
  endtask

  initial begin
    int i, ph;
    sb = new();
    sb.reset_all();
    rst = 1'b1;
    cfg_write = 1'b0; cfg_index = '0; cfg_data = '0;
    in_valid = 1'b0; in_data = '0;
    stall_enable = 1'b0;
    stream_sn = 0; stream_ang = 0; stream_vel = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    stall_enable = 1'b1;

    // Directed part with reset registers: stale sample zero after reset,
    // skip, priming, wrap of the angle step both ways, a closing window,
    // counter jump that saturates the window count, clear with all ones.
    send_beat(sample_beat(1'b0, 1'b1, 16'd0, 16'd100, 32'd0));
    send_beat(sample_beat(1'b0, 1'b0, 16'd5, 16'hFFFF, 32'h7FFFFFFF));
    send_beat(sample_beat(1'b0, 1'b1, 16'd1, 16'hFFF0, 32'h80000000));
    send_beat(sample_beat(1'b0, 1'b1, 16'd2, 16'h0010, 32'd0));
    send_beat(sample_beat(1'b0, 1'b1, 16'd3, 16'h8010, 32'd0));
    send_beat(sample_beat(1'b0, 1'b1, 16'd4, 16'h0010, 32'd0));
    send_beat(sample_beat(1'b0, 1'b1, 16'd30, 16'h0100, 32'd10));
    send_beat(sample_beat(1'b0, 1'b1, 16'd29, 16'h7FFF, 32'hFFFFFFFF));
    send_beat(sample_beat(1'b0, 1'b1, 16'd60, 16'hFFFF, 32'd0));
    send_beat(sample_beat(1'b0, 1'b1, 16'd80, 16'h0000, 32'd0));
    send_beat(sample_beat(1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF));
    send_beat(sample_beat(1'b0, 1'b1, 16'hFFFF, 16'h1234, 32'd0));
    for (i = 0; i < 21; i++)
      send_beat(sample_beat(1'b0, 1'b1, 16'(16'hFFFF + i + 1),
                            16'(16'h1234 + 3000 * i), 32'd0));

    // Extremes: huge scale with saturation, reverse, heavy filtering,
    // maximum pole pairs, zero-hold thresholds at their limits.
    set_regs(1'b1, 7'd127, 17'd65537, 32'hFFFFFFFF, 16'hFFFF, 31'h7FFFFFFF);
    random_phase(120);
    set_regs(1'b0, 7'd1, 17'd0, 32'd0, 16'd0, 31'd0);
    random_phase(80);
    set_regs(1'b1, 7'd64, 17'd1, 32'd62829824, 16'd256, 31'd1000);

    // Hold the sender until every predicted beat has come back.
    wait_drained();
    random_phase(120);
    for (ph = 0; ph < 8; ph++) begin
      set_regs(1'($urandom), 7'($urandom), 17'($urandom_range(65537)), $urandom,
               16'($urandom), 31'($urandom_range(200000)));
      stall_enable = (ph != 3);
      random_phase(110);
    end
    stall_enable = 1'b1;

    wait_drained();
    $display("Sent about 1230 sample beats over 12 register settings with gaps and stalls:");
    $display("%0d results checked, %0d speed windows.", sb.n_checked, sb.n_speed);
    if (sb.errors == 0 && sb.predicted_beats.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
